### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/csrab_pkg.sv
package csrab_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_EDGES    = 1024;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BUILT     = 3'd1,
    ST_BAD_VERT  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_BUILT = 3'd4,
    ST_PAST_DEG  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_CNT_RD,
    S_CNT,
    S_SCAN,
    S_SCT_RD,
    S_SCT,
    S_Q_RD,
    S_Q_HI,
    S_Q_EDGE,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  from_vertex;
    logic [7:0]  to_vertex;
    logic [31:0] weight;
    logic [15:0] edge_id;
    logic [9:0]  position;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] degree;
    logic [7:0]  out_to_vertex;
    logic [31:0] out_weight;
    logic [15:0] out_edge_id;
  } out_beat_t;

endpackage

### rtl/csrab_if.sv
interface csrab_in_if;
  logic                valid;
  logic                ready;
  csrab_pkg::in_beat_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface csrab_out_if;
  logic                 valid;
  logic                 ready;
  csrab_pkg::out_beat_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### rtl/csr_adjacency_builder.sv
// Compressed-sparse-row adjacency store. Add and query beats are taken one at a
// time; an add goes from S_IDLE straight to S_OUT, and a query steps through S_Q_RD,
// S_Q_HI and S_Q_EDGE for the registered reads of the offset and sorted edge
// memories. A build beat runs a pass clearing offsets, a counting pass over the
// pending edges, a prefix-sum pass over the vertices and a scatter pass.
// Each edge pass has a read state and an update state per edge because counts are
// read, modified and written back in one memory. Results leave through an output register.
module csr_adjacency_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  csrab_in_if.sink    in_ch,
  csrab_out_if.source out_ch
);
  `include "assert_macros.svh"

  localparam int MAX_VERTICES = csrab_pkg::MAX_VERTICES;
  localparam int MAX_EDGES    = csrab_pkg::MAX_EDGES;
  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int CW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int OW = EW + 1;

  logic [8:0] vertex_count;
  logic [VW-1:0] eff_n;
  always_comb begin
    if ({23'd0, vertex_count} < MAX_VERTICES) eff_n = VW'(vertex_count);
    else eff_n = VW'(MAX_VERTICES);
  end

  logic [63:0]   pend_mem [MAX_EDGES];
  logic [7:0]    src_mem  [MAX_EDGES];
  logic [63:0]   sort_mem [MAX_EDGES];
  logic [OW-1:0] off_mem  [MAX_VERTICES + 1];
  logic [OW-1:0] cur_mem  [MAX_VERTICES];

  csrab_pkg::fsm_t state, state_next;
  csrab_pkg::in_beat_t cur;
  logic [EW-1:0] edges_added;
  logic          is_built;
  logic [EW:0]   idx;
  logic [OW-1:0] acc, lo;
  logic [63:0]   pend_q, sort_q;
  logic [7:0]    src_q;
  logic [OW-1:0] off_q, cur_q;
  csrab_pkg::out_beat_t res;
  logic          out_valid;

  logic [VW-1:0] from_v, to_v, src_v;
  logic [OW-1:0] deg;
  logic [OW:0]   slot;
  logic [AW-1:0] e_ra;
  assign from_v = VW'(cur.from_vertex);
  assign to_v   = VW'(cur.to_vertex);
  assign src_v  = VW'(src_q);
  assign deg    = (off_q >= lo) ? off_q - lo : '0;
  assign slot   = {1'b0, lo} + (OW + 1)'(cur.position);
  assign e_ra   = (state == csrab_pkg::S_CLR || state == csrab_pkg::S_SCAN) ?
                  '0 : idx[AW-1:0];

  assign in_ch.ready    = (state == csrab_pkg::S_IDLE) && !out_valid;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = res;

  always_comb begin
    state_next = state;
    case (state)
      csrab_pkg::S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          if (in_ch.payload.kind == csrab_pkg::KIND_BUILD && !is_built)
            state_next = csrab_pkg::S_CLR;
          else if (in_ch.payload.kind == csrab_pkg::KIND_QUERY && is_built)
            state_next = csrab_pkg::S_Q_RD;
          else state_next = csrab_pkg::S_OUT;
        end
      end
      csrab_pkg::S_CLR:
        if (idx == (EW+1)'(MAX_VERTICES)) state_next = csrab_pkg::S_CNT_RD;
      csrab_pkg::S_CNT_RD:
        if (idx[EW-1:0] == edges_added) state_next = csrab_pkg::S_SCAN;
        else state_next = csrab_pkg::S_CNT;
      csrab_pkg::S_CNT: state_next = csrab_pkg::S_CNT_RD;
      csrab_pkg::S_SCAN:
        if (idx == (EW+1)'(MAX_VERTICES + 1)) state_next = csrab_pkg::S_SCT_RD;
      csrab_pkg::S_SCT_RD:
        if (idx[EW-1:0] == edges_added) state_next = csrab_pkg::S_OUT;
        else state_next = csrab_pkg::S_SCT;
      csrab_pkg::S_SCT: state_next = csrab_pkg::S_SCT_RD;
      csrab_pkg::S_Q_RD: state_next = csrab_pkg::S_Q_HI;
      csrab_pkg::S_Q_HI: state_next = csrab_pkg::S_Q_EDGE;
      csrab_pkg::S_Q_EDGE: state_next = csrab_pkg::S_OUT;
      csrab_pkg::S_OUT: state_next = csrab_pkg::S_IDLE;
      default: state_next = csrab_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csrab_pkg::S_IDLE;
      vertex_count <= 9'd256;
      edges_added <= '0;
      is_built <= 1'b0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) vertex_count <= cfg_wdata;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        csrab_pkg::S_IDLE: begin
          idx <= '0;
          if (in_ch.valid && in_ch.ready) begin
            cur <= in_ch.payload;
            res <= '0;
          end
        end
        csrab_pkg::S_CLR: begin
          if (idx == (EW+1)'(MAX_VERTICES)) idx <= '0;
          else idx <= idx + 1'b1;
        end
        csrab_pkg::S_CNT_RD: begin
          if (idx[EW-1:0] == edges_added) begin
            idx <= '0;
            acc <= '0;
          end else idx <= idx + 1'b1;
        end
        csrab_pkg::S_SCAN: begin
          if (idx == (EW+1)'(MAX_VERTICES + 1)) idx <= '0;
          else begin
            idx <= idx + 1'b1;
            if (idx != '0) acc <= acc + off_q;
          end
        end
        csrab_pkg::S_SCT_RD: begin
          if (idx[EW-1:0] == edges_added) is_built <= 1'b1;
          else idx <= idx + 1'b1;
        end
        csrab_pkg::S_Q_RD: begin
          if (from_v >= eff_n) begin
            res.status <= csrab_pkg::ST_BAD_VERT;
          end
        end
        csrab_pkg::S_Q_EDGE: begin
          if (res.status == csrab_pkg::ST_OK) begin
            res.degree <= 11'(deg);
            if ({22'd0, cur.position} >= 32'(deg)) res.status <= csrab_pkg::ST_PAST_DEG;
          end
        end
        csrab_pkg::S_OUT: begin
          out_valid <= 1'b1;
          if (cur.kind == csrab_pkg::KIND_ADD) begin
            if (is_built) res.status <= csrab_pkg::ST_BUILT;
            else if (from_v >= eff_n || to_v >= eff_n) res.status <= csrab_pkg::ST_BAD_VERT;
            else if (edges_added == EW'(MAX_EDGES)) res.status <= csrab_pkg::ST_FULL;
            else edges_added <= edges_added + 1'b1;
          end else if (cur.kind == csrab_pkg::KIND_QUERY) begin
            if (!is_built) res.status <= csrab_pkg::ST_NOT_BUILT;
            else if (res.status == csrab_pkg::ST_OK && slot < (OW+1)'(MAX_EDGES)) begin
              res.out_to_vertex <= sort_q[7:0];
              res.out_weight <= sort_q[39:8];
              res.out_edge_id <= sort_q[55:40];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Query: capture low offset after the first read.
  always_ff @(posedge clk) begin
    if (state == csrab_pkg::S_Q_HI) lo <= off_q;
  end

  // Memory ports.
  logic [VW-1:0] off_ra;
  always_comb begin
    off_ra = '0;
    case (state)
      csrab_pkg::S_CNT_RD: off_ra = src_v + 1'b1;
      csrab_pkg::S_SCAN:   off_ra = idx[VW-1:0];
      csrab_pkg::S_Q_RD:   off_ra = from_v;
      csrab_pkg::S_Q_HI:   off_ra = from_v + 1'b1;
      default:             off_ra = idx[VW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == csrab_pkg::S_IDLE && in_ch.valid && in_ch.ready
        && in_ch.payload.kind == csrab_pkg::KIND_ADD && !is_built
        && edges_added != EW'(MAX_EDGES)) begin
      pend_mem[edges_added[AW-1:0]] <= {8'd0, in_ch.payload.edge_id,
                                        in_ch.payload.weight, in_ch.payload.to_vertex};
      src_mem[edges_added[AW-1:0]] <= in_ch.payload.from_vertex;
    end
    pend_q <= pend_mem[e_ra];
    src_q  <= src_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    off_q <= off_mem[off_ra];
    if (state == csrab_pkg::S_CLR) off_mem[idx[VW-1:0]] <= '0;
    else if (state == csrab_pkg::S_CNT && src_v < eff_n)
      off_mem[src_v + 1'b1] <= off_q + 1'b1;
    else if (state == csrab_pkg::S_SCAN && idx != '0)
      off_mem[VW'(idx - 1'b1)] <= acc + off_q;
  end

  always_ff @(posedge clk) begin
    cur_q <= cur_mem[src_q];
    if (state == csrab_pkg::S_SCAN && idx != '0 && idx <= (EW+1)'(MAX_VERTICES))
      cur_mem[CW'(idx - 1'b1)] <= acc + off_q;
    else if (state == csrab_pkg::S_SCT && src_v < eff_n)
      cur_mem[src_q] <= cur_q + 1'b1;
  end

  always_ff @(posedge clk) begin
    sort_q <= sort_mem[slot[AW-1:0]];
    if (state == csrab_pkg::S_SCT && src_v < eff_n && cur_q < OW'(MAX_EDGES))
      sort_mem[cur_q[AW-1:0]] <= pend_q;
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, state != csrab_pkg::S_IDLE, !in_ch.ready, "accept while busy")
  `ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, edges_added <= EW'(MAX_EDGES), "edge count overflow")
  `ASSERT_NEXT(a_out_after, clk, rst, state == csrab_pkg::S_OUT, out_valid, "result not posted")
  `ASSERT_NEXT(a_built_sticky, clk, rst, is_built, is_built, "built flag cleared")

endmodule
